[rtl/ltmfd_pkg.sv]
package ltmfd_pkg;

   // header and function letters
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_T      = 8'h54;
   localparam logic [7:0] CHR_A      = 8'h41;
   localparam logic [7:0] CHR_S      = 8'h53;
   localparam logic [7:0] CHR_G      = 8'h47;
   localparam logic [7:0] CHR_O      = 8'h4F;
   localparam logic [7:0] CHR_N      = 8'h4E;
   localparam logic [7:0] CHR_X      = 8'h58;
   localparam logic [7:0] XOR_ZERO   = 8'h00;

   localparam int SIZE_W = 6;

   // register reset values
   localparam logic [SIZE_W-1:0] SIZE_ATTITUDE_RST = 6'd7;
   localparam logic [SIZE_W-1:0] SIZE_STATUS_RST   = 6'd8;
   localparam logic [SIZE_W-1:0] SIZE_GPS_RST      = 6'd15;
   localparam logic              PAIR_FRAMES_RST   = 1'b1;

   // register indexes
   typedef enum logic [1:0] {
      REG_SIZE_ATTITUDE = 2'd0,
      REG_SIZE_STATUS   = 2'd1,
      REG_SIZE_GPS      = 2'd2,
      REG_PAIR_FRAMES   = 2'd3
   } ltmfd_reg_type;

   // frame type codes
   typedef enum logic [2:0] {
      FT_A = 3'd0,
      FT_S = 3'd1,
      FT_G = 3'd2,
      FT_O = 3'd3,
      FT_N = 3'd4,
      FT_X = 3'd5
   } ltmfd_ftype_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } ltmfd_req_type;

   typedef struct packed {
      logic            has_byte;
      logic [7:0]      data_byte;
      logic            frame_start;
      ltmfd_ftype_type frame_type;
      logic            frame_end;
      logic            crc_ok;
      logic            packet_end;
   } ltmfd_rsp_type;

   typedef struct packed {
      ltmfd_reg_type     reg_index;
      logic [SIZE_W-1:0] wdata;
   } ltmfd_csr_type;

   // configuration as seen by the parser
   typedef struct packed {
      logic [SIZE_W-1:0] size_attitude;
      logic [SIZE_W-1:0] size_status;
      logic [SIZE_W-1:0] size_gps;
      logic              pair_frames;
   } ltmfd_cfg_type;

endpackage

[rtl/ltmfd_stream_if.sv]
interface ltmfd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/ltm_frame_deframer_unit.sv]
// LTM telemetry frame deframer
//
// req: one serial byte per transaction (rx_byte). rsp: at most one result
// per accepted byte: a start item carrying the function letter, one item
// per payload byte (frame_end and crc_ok on the last), or a bare packet
// end marker (has_byte 0). Header bytes and skipped bytes give nothing.
// csr: register writes (size_attitude, size_status, size_gps,
// pair_frames), always ready; write only while the block is idle.
//
// Latency: a result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle, set by the single result register in
// front of rsp. req.ready stays high while that register is empty or is
// being taken, so a stalled receiver holds one result and then stops req.
// Reset (synchronous) returns to hunting for '$', releases any held frame,
// clears the result register and loads the register reset values.
module ltm_frame_deframer_unit (
   input logic  clock,
   input logic  reset,
   ltmfd_stream_if.sink   req,
   ltmfd_stream_if.source rsp,
   ltmfd_stream_if.sink   csr
);

   ltmfd_pkg::ltmfd_cfg_type cfg_ff, cfg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ltmfd_pkg::ltmfd_rsp_type rsp_data_ff;

   logic                     req_take;
   logic                     result_valid;
   ltmfd_pkg::ltmfd_rsp_type result;

   // input accepted while the result register is free or draining
   assign req.ready = ~rsp_valid_ff | rsp.ready;
   assign req_take  = req.valid & req.ready;
   assign csr.ready = 1'b1;

   ltmfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (req_take),
      .rx_byte      (req.payload.rx_byte),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.payload.reg_index)
            ltmfd_pkg::REG_SIZE_ATTITUDE: cfg_in.size_attitude = csr.payload.wdata;
            ltmfd_pkg::REG_SIZE_STATUS:   cfg_in.size_status   = csr.payload.wdata;
            ltmfd_pkg::REG_SIZE_GPS:      cfg_in.size_gps      = csr.payload.wdata;
            ltmfd_pkg::REG_PAIR_FRAMES:   cfg_in.pair_frames   = csr.payload.wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_attitude <= ltmfd_pkg::SIZE_ATTITUDE_RST;
         cfg_ff.size_status   <= ltmfd_pkg::SIZE_STATUS_RST;
         cfg_ff.size_gps      <= ltmfd_pkg::SIZE_GPS_RST;
         cfg_ff.pair_frames   <= ltmfd_pkg::PAIR_FRAMES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      if (req_take && result_valid) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && result_valid) rsp_data_ff <= result;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

`ifndef ASSERT_OFF
   // a produced result is always captured
   a_result_captured: assert property (@(posedge clock) disable iff (reset)
      (req_take && result_valid) |=> rsp_valid_ff)
      else $error("result lost");

   // bare packet end carries no other flags
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.has_byte) |->
      (rsp_data_ff.packet_end && !rsp_data_ff.frame_start &&
       !rsp_data_ff.frame_end && rsp_data_ff.data_byte == ltmfd_pkg::XOR_ZERO))
      else $error("malformed bare packet end");

   // packet end and crc flags only at a frame end or a flush
   a_end_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.has_byte && !rsp_data_ff.frame_end) |->
      (!rsp_data_ff.packet_end && !rsp_data_ff.crc_ok))
      else $error("end flags outside frame end");
`endif

endmodule

[rtl/ltmfd_parser.sv]
module ltmfd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   input  ltmfd_pkg::ltmfd_cfg_type cfg,
   output logic                    result_valid,
   output ltmfd_pkg::ltmfd_rsp_type result
);

   typedef enum logic [3:0] {
      PH_DOLLAR  = 4'b0001,
      PH_T       = 4'b0010,
      PH_FUNC    = 4'b0100,
      PH_PAYLOAD = 4'b1000
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [ltmfd_pkg::SIZE_W-1:0]    left_ff, left_in;
   logic [7:0]                      xor_ff, xor_in;
   ltmfd_pkg::ltmfd_ftype_type      ctype_ff, ctype_in;
   logic                            held_ff, held_in;

   logic                            known;
   ltmfd_pkg::ltmfd_ftype_type      dec_type;
   logic [ltmfd_pkg::SIZE_W-1:0]    dec_len;
   logic [ltmfd_pkg::SIZE_W-1:0]    left_dec;
   logic [7:0]                      xor_next;
   logic                            pend;
   logic                            held_close;

   // function letter decode
   always_comb begin
      known    = 1'b1;
      dec_type = ltmfd_pkg::FT_A;
      dec_len  = cfg.size_attitude;
      unique case (rx_byte)
         ltmfd_pkg::CHR_A: begin dec_type = ltmfd_pkg::FT_A; dec_len = cfg.size_attitude; end
         ltmfd_pkg::CHR_S: begin dec_type = ltmfd_pkg::FT_S; dec_len = cfg.size_status; end
         ltmfd_pkg::CHR_G: begin dec_type = ltmfd_pkg::FT_G; dec_len = cfg.size_gps; end
         ltmfd_pkg::CHR_O: begin dec_type = ltmfd_pkg::FT_O; dec_len = cfg.size_gps; end
         ltmfd_pkg::CHR_N: begin dec_type = ltmfd_pkg::FT_N; dec_len = cfg.size_attitude; end
         ltmfd_pkg::CHR_X: begin dec_type = ltmfd_pkg::FT_X; dec_len = cfg.size_attitude; end
         default: known = 1'b0;
      endcase
   end

   // packet end decision at a frame end
   always_comb begin
      if (cfg.pair_frames) begin
         pend       = held_ff;
         held_close = ~held_ff;
      end else begin
         pend       = 1'b1;
         held_close = 1'b0;
      end
   end

   assign left_dec = left_ff - 1'b1;
   assign xor_next = xor_ff ^ rx_byte;

   // per-byte state update
   always_comb begin
      phase_in     = phase_ff;
      left_in      = left_ff;
      xor_in       = xor_ff;
      ctype_in     = ctype_ff;
      held_in      = held_ff;
      result_valid = 1'b0;
      result       = '0;
      unique case (phase_ff)
         PH_DOLLAR: begin
            if (rx_byte == ltmfd_pkg::CHR_DOLLAR) phase_in = PH_T;
         end
         PH_T: begin
            phase_in = (rx_byte == ltmfd_pkg::CHR_T) ? PH_FUNC : PH_DOLLAR;
         end
         PH_FUNC: begin
            if (!known) begin
               phase_in = PH_DOLLAR;
               if (held_ff) begin
                  held_in           = 1'b0;
                  result_valid      = 1'b1;
                  result.packet_end = 1'b1;
               end
            end else begin
               ctype_in           = dec_type;
               xor_in             = ltmfd_pkg::XOR_ZERO;
               left_in            = dec_len;
               result_valid       = 1'b1;
               result.has_byte    = 1'b1;
               result.data_byte   = rx_byte;
               result.frame_start = 1'b1;
               result.frame_type  = dec_type;
               // empty payload: start item closes the frame
               if (dec_len == '0) begin
                  phase_in          = PH_DOLLAR;
                  held_in           = held_close;
                  result.frame_end  = 1'b1;
                  result.crc_ok     = 1'b1;
                  result.packet_end = pend;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            xor_in            = xor_next;
            left_in           = left_dec;
            result_valid      = 1'b1;
            result.has_byte   = 1'b1;
            result.data_byte  = rx_byte;
            result.frame_type = ctype_ff;
            if (left_dec == '0) begin
               phase_in          = PH_DOLLAR;
               held_in           = held_close;
               result.frame_end  = 1'b1;
               result.crc_ok     = (xor_next == ltmfd_pkg::XOR_ZERO);
               result.packet_end = pend;
            end
         end
         default: phase_in = PH_DOLLAR;
      endcase
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DOLLAR;
         left_ff  <= '0;
         xor_ff   <= '0;
         ctype_ff <= ltmfd_pkg::FT_A;
         held_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         xor_ff   <= xor_in;
         ctype_ff <= ctype_in;
         held_ff  <= held_in;
      end
   end

endmodule
